FILE: src/bpa_pkg.sv
package bpa_pkg;

	// Field and counter widths
	localparam int unsigned PAGE_W     = 16;
	localparam int unsigned CNT_W      = 17;
	localparam int unsigned STAT_W     = 2;
	localparam int unsigned OP_W       = 1;
	localparam int unsigned OUT_DATA_W = 56;
	localparam int unsigned OUT_PAD_W  = OUT_DATA_W - PAGE_W - 2 * CNT_W;

	// Configuration port
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;
	localparam logic [APB_ADDR_W-1:0] REG_PAGE_LIMIT = 3'd0;

	// Request kinds
	localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
	localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

	// Result status codes
	localparam logic [STAT_W-1:0] STAT_ALLOC   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_OOM     = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FREED   = 2'd2;
	localparam logic [STAT_W-1:0] STAT_IGNORED = 2'd3;

	// Request sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADDR,
		ST_SCAN,
		ST_FREE,
		ST_PUSH
	} st_t;

endpackage

FILE: src/bpa_ram.sv
module bpa_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]    waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]    raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: src/bitmap_page_allocator_unit.sv
// Sequence: an accepted request passes ST_ADDR, then ST_SCAN (alloc) or ST_FREE (free),
// then ST_PUSH; each bitmap word scanned beyond the hint word adds a further ST_SCAN step.
// A new request is taken only in ST_IDLE, after the last result entered the output register.
// Words are read through the single read port of the bitmap RAM (one for a free; up to
// MAX_PAGES/WORD_BITS + 1 for a full scan). Reset fills the bitmap RAM with ones (every page
// used) over all MAX_PAGES/WORD_BITS words (1024 by default); page_limit writes rerun it.
module bitmap_page_allocator_unit #(
	parameter int unsigned MAX_PAGES = 65536,
	parameter int unsigned WORD_BITS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request: tdata = page_index[15:0]; tuser = op[0]
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [bpa_pkg::PAGE_W-1:0]      s_axis_tdata,
	input  logic [bpa_pkg::OP_W-1:0]        s_axis_tuser,
	// result: tdata = result_page[15:0], used_count[32:16], free_count[49:33], zero[55:50];
	// tuser = status[1:0]
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [bpa_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	output logic [bpa_pkg::STAT_W-1:0]      m_axis_tuser,
	// configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [bpa_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [bpa_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [bpa_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);

	import bpa_pkg::*;

	localparam int unsigned DEPTH   = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int unsigned AW      = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int unsigned BW      = $clog2(WORD_BITS);
	localparam int unsigned PW      = CNT_W;
	// Reciprocal for page / WORD_BITS, exact for every PW-bit page number
	localparam int unsigned DIV_SH  = PW + BW;
	localparam int unsigned DIV_MW  = PW + 2;
	localparam int unsigned PRODW   = DIV_SH + PW;
	localparam logic [63:0] DIV_M64 = ((64'd1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;
	localparam logic [DIV_MW-1:0] DIV_M = DIV_M64[DIV_MW-1:0];
	localparam logic [PW-1:0] W_P   = PW'(WORD_BITS);
	localparam logic [PW:0]   W_X   = (PW + 1)'(WORD_BITS);
	localparam int unsigned   CMAX_I = MAX_PAGES < 131071 ? MAX_PAGES : 131071;
	localparam logic [PW-1:0] LIMIT_MAX = PW'(CMAX_I);
	localparam int unsigned   LRST_I = MAX_PAGES < 65536 ? MAX_PAGES : 65536;
	localparam logic [PW-1:0] LIMIT_RST = PW'(LRST_I);
	localparam logic [AW-1:0] SWEEP_LAST = AW'(DEPTH - 1);

	// Word number of a page
	function automatic logic [PW-1:0] page_word(input logic [PW-1:0] x);
		logic [PRODW-1:0] prod;
		prod = PRODW'(x) * PRODW'(DIV_M);
		return prod[DIV_SH +: PW];
	endfunction

	// Bits of the word at base whose page lies in [lo, hi)
	function automatic logic [WORD_BITS-1:0] range_mask(input logic [PW-1:0] lo,
			input logic [PW-1:0] hi, input logic [PW-1:0] base);
		logic [PW:0]          d_lo;
		logic [PW:0]          d_hi;
		logic [WORD_BITS-1:0] m_lo;
		logic [WORD_BITS-1:0] m_hi;
		d_lo = {1'b0, lo} - {1'b0, base};
		d_hi = {1'b0, hi} - {1'b0, base};
		m_lo = '1;
		if (lo > base) begin
			if (d_lo >= W_X) m_lo = '0;
			else m_lo = {WORD_BITS{1'b1}} << d_lo[BW-1:0];
		end
		m_hi = '0;
		if (hi > base) begin
			if (d_hi >= W_X) m_hi = '1;
			else m_hi = ~({WORD_BITS{1'b1}} << d_hi[BW-1:0]);
		end
		return m_lo & m_hi;
	endfunction

	// Lowest set bit
	function automatic logic [BW-1:0] lowest_bit(input logic [WORD_BITS-1:0] v);
		logic [BW-1:0] r;
		r = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) r = BW'(i);
		end
		return r;
	endfunction

	st_t state_q, state_d;

	logic [OP_W-1:0]      op_q;
	logic [PW-1:0]        idx_q;
	logic [PW-1:0]        hint_q;
	logic [PW-1:0]        word_q;
	logic [PW-1:0]        base_q;
	logic                 phase_q;
	logic [PW-1:0]        limit_q;
	logic [PW-1:0]        used_q;
	logic [PW-1:0]        ss_q;
	logic                 sweep_act_q;
	logic [AW-1:0]        sweep_q;
	logic [STAT_W-1:0]    res_status_q;
	logic [PAGE_W-1:0]    res_page_q;
	logic                 ovld_q;
	logic [STAT_W-1:0]    ostatus_q;
	logic [PAGE_W-1:0]    opage_q;
	logic [PW-1:0]        oused_q;
	logic [PW-1:0]        ofree_q;

	logic                 in_acc;
	logic                 cfg_wr;
	logic [PW-1:0]        cfg_limit;
	logic [PW-1:0]        hint_d;
	logic [PW-1:0]        lo;
	logic [PW-1:0]        hi;
	logic [WORD_BITS-1:0] rdata;
	logic [WORD_BITS-1:0] cand;
	logic                 found;
	logic [BW-1:0]        bit_sel;
	logic [PW-1:0]        found_page;
	logic [PW:0]          next_base;
	logic                 last_word;
	logic [PW-1:0]        next_word;
	logic [BW-1:0]        free_bit;
	logic                 free_ok;
	logic                 push_go;
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [AW-1:0]        ram_raddr;

	// Handshakes and configuration decode
	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign cfg_wr    = psel && penable && pwrite && pready && (paddr == REG_PAGE_LIMIT);
	assign cfg_limit = (pwdata[PW-1:0] > LIMIT_MAX) ? LIMIT_MAX : pwdata[PW-1:0];
	assign pready    = 1'b1;
	assign prdata    = {{(APB_DATA_W - PW){1'b0}}, limit_q};
	assign hint_d    = (ss_q < limit_q) ? ss_q : limit_q;

	// Scan window: hint up to limit first, then page 0 up to hint
	assign lo         = phase_q ? '0 : hint_q;
	assign hi         = phase_q ? hint_q : limit_q;
	assign cand       = ~rdata & range_mask(lo, hi, base_q);
	assign found      = |cand;
	assign bit_sel    = lowest_bit(cand);
	assign found_page = base_q + PW'(bit_sel);
	assign next_base  = {1'b0, base_q} + W_X;
	assign last_word  = next_base >= {1'b0, hi};
	assign next_word  = word_q + PW'(1);

	// Free lookup
	assign free_bit = BW'(idx_q - base_q);
	assign free_ok  = (idx_q < limit_q) && rdata[free_bit];

	assign push_go = !ovld_q || m_axis_tready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_acc) state_d = ST_ADDR;
			ST_ADDR: state_d = (op_q == OP_FREE) ? ST_FREE : ST_SCAN;
			ST_SCAN: if (found || (last_word && phase_q)) state_d = ST_PUSH;
			ST_FREE: state_d = ST_PUSH;
			ST_PUSH: if (push_go) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs and RAM controls
	always_comb begin
		s_axis_tready = 1'b0;
		ram_we        = 1'b0;
		ram_waddr     = word_q[AW-1:0];
		ram_wdata     = rdata;
		ram_raddr     = word_q[AW-1:0];
		unique case (state_q)
			ST_IDLE: s_axis_tready = !sweep_act_q;
			ST_ADDR: ram_raddr = word_q[AW-1:0];
			ST_SCAN: begin
				if (found) begin
					ram_we    = 1'b1;
					ram_wdata = rdata | (WORD_BITS'(1) << bit_sel);
				end else if (last_word && !phase_q) begin
					ram_raddr = '0;
				end else begin
					ram_raddr = next_word[AW-1:0];
				end
			end
			ST_FREE: begin
				ram_we    = free_ok;
				ram_wdata = rdata & ~(WORD_BITS'(1) << free_bit);
			end
			ST_PUSH: ;
			default: ;
		endcase
		if (sweep_act_q) begin
			ram_we    = 1'b1;
			ram_waddr = sweep_q;
			ram_wdata = '1;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sweep_act_q <= 1'b1;
			sweep_q     <= '0;
			limit_q     <= LIMIT_RST;
			used_q      <= LIMIT_RST;
			ss_q        <= '0;
			ovld_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			// fill pass: restart on a limit write
			if (cfg_wr) begin
				sweep_act_q <= 1'b1;
				sweep_q     <= '0;
				limit_q     <= cfg_limit;
				used_q      <= cfg_limit;
				ss_q        <= '0;
			end else if (sweep_act_q) begin
				sweep_q <= sweep_q + AW'(1);
				if (sweep_q == SWEEP_LAST) sweep_act_q <= 1'b0;
			end
			// commit counters and hint
			if (state_q == ST_SCAN && found) begin
				used_q <= used_q + PW'(1);
				ss_q   <= found_page + PW'(1);
			end
			if (state_q == ST_FREE && free_ok) begin
				if (used_q != '0) used_q <= used_q - PW'(1);
				if (idx_q < ss_q) ss_q <= idx_q;
			end
			// output register
			if (state_q == ST_PUSH && push_go) ovld_q <= 1'b1;
			else if (m_axis_tready) ovld_q <= 1'b0;
		end
	end

	// Request payload, scan position and results
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q   <= s_axis_tuser;
			idx_q  <= PW'(s_axis_tdata);
			hint_q <= hint_d;
			word_q <= page_word((s_axis_tuser == OP_FREE) ? PW'(s_axis_tdata) : hint_d);
		end
		case (state_q)
			ST_ADDR: begin
				base_q  <= word_q * W_P;
				phase_q <= 1'b0;
			end
			ST_SCAN: begin
				if (found) begin
					res_status_q <= STAT_ALLOC;
					res_page_q   <= found_page[PAGE_W-1:0];
				end else if (last_word && phase_q) begin
					res_status_q <= STAT_OOM;
					res_page_q   <= '0;
				end else if (last_word) begin
					phase_q <= 1'b1;
					word_q  <= '0;
					base_q  <= '0;
				end else begin
					word_q <= next_word;
					base_q <= next_base[PW-1:0];
				end
			end
			ST_FREE: begin
				res_status_q <= free_ok ? STAT_FREED : STAT_IGNORED;
				res_page_q   <= '0;
			end
			ST_PUSH: begin
				if (push_go) begin
					ostatus_q <= res_status_q;
					opage_q   <= res_page_q;
					oused_q   <= used_q;
					ofree_q   <= (limit_q > used_q) ? (limit_q - used_q) : '0;
				end
			end
			default: ;
		endcase
	end

	bpa_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (DEPTH)
	) u_bitmap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	assign m_axis_tvalid = ovld_q;
	assign m_axis_tuser  = ostatus_q;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, ofree_q, oused_q, opage_q};

	// Checks
	a_sweep_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_act_q |-> !s_axis_tready)
		else $error("request accepted during bitmap fill");

	a_used_le_limit: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= limit_q)
		else $error("used page count above limit");

	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && !sweep_act_q) |-> (state_q == ST_SCAN || state_q == ST_FREE))
		else $error("bitmap write outside scan or free");

	a_out_from_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_PUSH))
		else $error("result raised without push");

endmodule

FILE: test/bitmap_page_allocator_checker.sv
`timescale 1ns / 1ps

module bitmap_page_allocator_checker #(
	parameter int unsigned MAX_PAGES = 65536
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [bpa_pkg::PAGE_W-1:0]     s_axis_tdata,
	input  logic [bpa_pkg::OP_W-1:0]       s_axis_tuser,
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [bpa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic [bpa_pkg::STAT_W-1:0]     m_axis_tuser,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bpa_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [bpa_pkg::APB_DATA_W-1:0] pwdata,
	input  logic [bpa_pkg::APB_DATA_W-1:0] prdata,
	input  logic                           pready,
	output int                             errors,
	output int                             pending,
	output int                             n_alloc,
	output int                             n_oom,
	output int                             n_freed,
	output int                             n_ignored
);

	import bpa_pkg::*;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [PAGE_W-1:0] page;
		logic [CNT_W-1:0]  used;
		logic [CNT_W-1:0]  avail;
	} page_result_t;

	// Shadow allocator state
	bit               page_taken [MAX_PAGES];
	logic [CNT_W-1:0] next_hint;
	logic [CNT_W-1:0] busy_count;
	logic [CNT_W-1:0] limit_pages;

	page_result_t awaited_results [$];

	task automatic report_mismatch(input string msg);
		errors++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	function automatic logic [CNT_W-1:0] clamp_limit(input logic [APB_DATA_W-1:0] wr);
		logic [CNT_W-1:0] v;
		v = wr[CNT_W-1:0];
		if (v > MAX_PAGES)
			v = CNT_W'(MAX_PAGES);
		return v;
	endfunction

	// Mark every page used and restart the hint
	task automatic reset_bitmap(input logic [CNT_W-1:0] lim);
		foreach (page_taken[i])
			page_taken[i] = 1'b1;
		limit_pages = lim;
		busy_count  = lim;
		next_hint   = '0;
	endtask

	// Take the first free page in [lo, hi)
	task automatic claim_first(input int lo, input int hi, output bit hit,
			output logic [PAGE_W-1:0] page);
		hit  = 1'b0;
		page = '0;
		for (int p = lo; p < hi; p++) begin
			if (!page_taken[p]) begin
				page_taken[p] = 1'b1;
				busy_count    = busy_count + CNT_W'(1);
				next_hint     = CNT_W'(p + 1);
				page          = p[PAGE_W-1:0];
				hit           = 1'b1;
				return;
			end
		end
	endtask

	task automatic predict_request(input logic [OP_W-1:0] op, input logic [PAGE_W-1:0] idx,
			output page_result_t r);
		int                lo;
		bit                hit;
		logic [PAGE_W-1:0] pg;
		pg = '0;
		if (op == OP_ALLOC) begin
			// next fit from the hint, then wrap once from page 0
			lo = (next_hint < limit_pages) ? int'(next_hint) : int'(limit_pages);
			claim_first(lo, int'(limit_pages), hit, pg);
			if (!hit)
				claim_first(0, lo, hit, pg);
			r.status = hit ? STAT_ALLOC : STAT_OOM;
			if (!hit)
				pg = '0;
		end else if (idx < limit_pages && page_taken[idx]) begin
			page_taken[idx] = 1'b0;
			if (busy_count > 0)
				busy_count = busy_count - CNT_W'(1);
			if (idx < next_hint)
				next_hint = CNT_W'(idx);
			r.status = STAT_FREED;
		end else begin
			r.status = STAT_IGNORED;
		end
		r.page  = pg;
		r.used  = busy_count;
		r.avail = (limit_pages > busy_count) ? limit_pages - busy_count : '0;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		page_result_t want;
		page_result_t fresh;
		if (!arst_n) begin
			awaited_results.delete();
			reset_bitmap(clamp_limit(APB_DATA_W'(65536)));
			errors    = 0;
			pending   = 0;
			n_alloc   = 0;
			n_oom     = 0;
			n_freed   = 0;
			n_ignored = 0;
		end else begin
			// compare a delivered result with the oldest prediction
			if (m_axis_tvalid && m_axis_tready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch($sformatf("result with no request waiting: status %0d page %0d",
						m_axis_tuser, m_axis_tdata[PAGE_W-1:0]));
				end else begin
					want = awaited_results.pop_front();
					check_field("status", 32'(m_axis_tuser), 32'(want.status));
					check_field("result_page", 32'(m_axis_tdata[PAGE_W-1:0]),
						32'(want.page));
					check_field("used_count", 32'(m_axis_tdata[PAGE_W+CNT_W-1:PAGE_W]),
						32'(want.used));
					check_field("free_count",
						32'(m_axis_tdata[PAGE_W+2*CNT_W-1:PAGE_W+CNT_W]), 32'(want.avail));
					check_field("tdata pad", 32'(m_axis_tdata[OUT_DATA_W-1:PAGE_W+2*CNT_W]),
						32'd0);
				end
				case (m_axis_tuser)
					STAT_ALLOC: n_alloc++;
					STAT_OOM:   n_oom++;
					STAT_FREED: n_freed++;
					default:    n_ignored++;
				endcase
			end
			// predict each accepted request
			if (s_axis_tvalid && s_axis_tready) begin
				predict_request(s_axis_tuser, s_axis_tdata, fresh);
				awaited_results.push_back(fresh);
			end
			// follow register writes, check register reads
			if (psel && penable && pready && paddr == REG_PAGE_LIMIT) begin
				if (pwrite)
					reset_bitmap(clamp_limit(pwdata));
				else
					check_field("page_limit read", prdata, APB_DATA_W'(limit_pages));
			end
			pending = awaited_results.size();
		end
	end

endmodule

FILE: test/bitmap_page_allocator_unit_tb.sv
`timescale 1ns / 1ps

module bitmap_page_allocator_unit_tb;
	import bpa_pkg::*;

	localparam int unsigned MAX_PAGES = 65536;
	localparam int unsigned RANDOM_REQUESTS = 1500;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	// request: tdata = page_index; tuser = op
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [PAGE_W-1:0]     s_axis_tdata = '0;
	logic [OP_W-1:0]       s_axis_tuser = OP_ALLOC;
	// result: tdata = result_page, used_count, free_count, pad; tuser = status
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [STAT_W-1:0]     m_axis_tuser;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = REG_PAGE_LIMIT;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int errors, pending, n_alloc, n_oom, n_freed, n_ignored;
	int n_requests = 0;
	int n_settings = 0;
	bit src_idle  = 1'b1;
	bit sink_idle = 1'b1;

	bitmap_page_allocator_unit #(
		.MAX_PAGES(MAX_PAGES),
		.WORD_BITS(64)
	) i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	bitmap_page_allocator_checker #(
		.MAX_PAGES(MAX_PAGES)
	) i_checker (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.errors(errors), .pending(pending),
		.n_alloc(n_alloc), .n_oom(n_oom), .n_freed(n_freed), .n_ignored(n_ignored)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hold tready low for a random stall after each result while sink_idle is set
	initial begin : result_sink
		int stall;
		stall = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				stall = sink_idle ? $urandom_range(0, 3) : 0;
			@(negedge clk);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				stall--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Offer one request, after a random gap while src_idle is set, and wait for its acceptance
	task automatic send_request(input logic [OP_W-1:0] op, input logic [PAGE_W-1:0] idx);
		int gap;
		gap = src_idle ? $urandom_range(0, 3) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= idx;
		s_axis_tuser  <= op;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		n_requests++;
	endtask

	task automatic apb_access(input bit wr, input logic [APB_DATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= REG_PAGE_LIMIT;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Write the limit, then read it back
	task automatic set_limit(input logic [APB_DATA_W-1:0] data);
		apb_access(1'b1, data);
		apb_access(1'b0, '0);
		n_settings++;
	endtask

	// Stop offering requests and wait until every result is back
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	initial begin : stimulus
		int n_directed;
		int limit;
		int pick_lo;
		int pick_hi;
		int mix;
		int alloc_pct;
		int r;
		logic [PAGE_W-1:0] idx;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// full map after reset: out of memory, double free, edge pages, wrap
		send_request(OP_ALLOC, 16'hFFFF);
		send_request(OP_FREE, 16'h0000);
		send_request(OP_FREE, 16'h0000);
		send_request(OP_FREE, 16'hFFFF);
		send_request(OP_ALLOC, 16'h0000);
		send_request(OP_ALLOC, 16'h0000);
		send_request(OP_ALLOC, 16'h1234);
		send_request(OP_FREE, 16'h5555);
		send_request(OP_FREE, 16'hAAAA);
		settle();

		// zero limit: nothing to allocate, nothing to free
		set_limit(32'h0000_0000);
		send_request(OP_ALLOC, 16'h0000);
		send_request(OP_FREE, 16'h0000);
		settle();

		// upper data bits dropped: limit 40, free beyond the limit ignored
		set_limit(32'hFFFE_0028);
		send_request(OP_FREE, 16'd39);
		send_request(OP_FREE, 16'd40);
		send_request(OP_FREE, 16'd1);
		send_request(OP_ALLOC, 16'd0);
		send_request(OP_ALLOC, 16'd0);
		send_request(OP_ALLOC, 16'd0);
		settle();

		// oversize limit held at the maximum
		set_limit(32'h0001_FFFF);
		send_request(OP_FREE, 16'hFFFF);
		send_request(OP_ALLOC, 16'h0000);
		settle();

		// single page
		set_limit(32'd1);
		send_request(OP_FREE, 16'd0);
		send_request(OP_ALLOC, 16'd0);
		send_request(OP_ALLOC, 16'd0);
		settle();
		n_directed = n_requests;

		// random phases: reinit, software frees usable pages, then mixed traffic
		while (n_requests - n_directed < RANDOM_REQUESTS) begin
			r = $urandom_range(0, 9);
			if (r == 0)
				limit = MAX_PAGES;
			else if (r == 1)
				limit = $urandom_range(1, 3);
			else if (r == 2)
				limit = $urandom_range(0, 1) ? 64 : 128;
			else
				limit = $urandom_range(4, 200);
			src_idle  = $urandom_range(0, 3) != 0;
			sink_idle = $urandom_range(0, 3) != 0;
			alloc_pct = $urandom_range(30, 70);
			set_limit(limit);

			if (limit == MAX_PAGES) begin
				// keep the big map mostly used so scans stay bounded
				pick_lo = $urandom_range(1, MAX_PAGES - 48);
				pick_hi = pick_lo + 40;
				for (int k = 0; k < 32; k++)
					send_request(OP_FREE, PAGE_W'(pick_lo + k));
				mix = 24;
			end else begin
				pick_lo = 0;
				pick_hi = limit - 1;
				if ($urandom_range(0, 7) == 0)
					send_request(OP_FREE, '0);
				for (int p = 1; p < limit; p++)
					if ($urandom_range(0, 7) != 0)
						send_request(OP_FREE, PAGE_W'(p));
				mix = $urandom_range(limit, 2 * limit + 16);
			end

			for (int k = 0; k < mix; k++) begin
				if ($urandom_range(0, 99) < alloc_pct) begin
					send_request(OP_ALLOC, PAGE_W'($urandom));
				end else begin
					r = $urandom_range(0, 99);
					if (r < 80)
						idx = PAGE_W'($urandom_range(pick_lo, pick_hi));
					else if (r < 95 && limit < MAX_PAGES)
						idx = PAGE_W'($urandom_range(limit, 65535));
					else
						idx = PAGE_W'($urandom);
					send_request(OP_FREE, idx);
				end
			end
			settle();
		end

		$display("covered %0d requests (%0d directed) over %0d limit settings",
			n_requests, n_directed, n_settings);
		$display("results: %0d allocated, %0d out of memory, %0d freed, %0d ignored",
			n_alloc, n_oom, n_freed, n_ignored);
		if (errors == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		#(100_000_000);
		$display("timeout with %0d results outstanding", pending);
		$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: bitmap_page_allocator_unit.f
src/bpa_pkg.sv
src/bpa_ram.sv
src/bitmap_page_allocator_unit.sv
test/bitmap_page_allocator_checker.sv
test/bitmap_page_allocator_unit_tb.sv
